>>> rtl/nonc_pkg.sv
// ----------------------------------------------------------------------------
// nonc_pkg - natural order name compare package
// Shared types, character codes and order codes of the name comparator.
// ----------------------------------------------------------------------------
package nonc_pkg;

  localparam int unsigned NAME_BYTES_DEF = 256;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UP_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LOW_A = 8'h61;  // 'a'

  // Order codes
  localparam logic signed [1:0] ORD_LT = 2'sb11;
  localparam logic signed [1:0] ORD_EQ = 2'sb00;
  localparam logic signed [1:0] ORD_GT = 2'sb01;

  // Status of the compare sequencer toward the top level
  typedef struct packed {
    logic              idle;
    logic              done;
    logic signed [1:0] order;
  } nonc_stat_t;

  function automatic logic [7:0] fold_ch(input logic [7:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      return 8'(c - CH_UP_A + CH_LOW_A);
    end
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

>>> rtl/nonc_ram.sv
// ----------------------------------------------------------------------------
// nonc_ram - generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nonc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 255,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/nonc_cmp.sv
// ----------------------------------------------------------------------------
// nonc_cmp - shared compare unit
// Compares two operands (bytes, optionally case folded, or digit run
// lengths) and classifies the byte operands as digits or zeros.
// ----------------------------------------------------------------------------
module nonc_cmp
  import nonc_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             fold_i,
  output logic             lt_o,
  output logic             eq_o,
  output logic             a_num_o,
  output logic             b_num_o,
  output logic             a_zero_o,
  output logic             b_zero_o
);

  logic [WIDTH-1:0] fa, fb;

  always_comb begin
    fa = fold_i ? WIDTH'(fold_ch(a_i[7:0])) : a_i;
    fb = fold_i ? WIDTH'(fold_ch(b_i[7:0])) : b_i;
  end

  assign lt_o     = fa < fb;
  assign eq_o     = fa == fb;
  assign a_num_o  = is_digit(a_i[7:0]);
  assign b_num_o  = is_digit(b_i[7:0]);
  assign a_zero_o = a_i[7:0] == CH_ZERO;
  assign b_zero_o = b_i[7:0] == CH_ZERO;

endmodule

>>> rtl/nonc_walk.sv
// ----------------------------------------------------------------------------
// nonc_walk - compare sequencer
// Walks both stored names through the shared compare unit, each step a read
// state and then an evaluate state, and holds the order until it is taken.
// ----------------------------------------------------------------------------
module nonc_walk
  import nonc_pkg::*;
#(
  parameter int unsigned NAME_BYTES = NAME_BYTES_DEF,
  localparam int unsigned DEPTH = NAME_BYTES - 1,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned LW = $clog2(NAME_BYTES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          dir_a_i,
  input  logic          dir_b_i,
  input  logic [LW-1:0] len_a_i,
  input  logic [LW-1:0] len_b_i,
  input  logic [7:0]    rdata_a_i,
  input  logic [7:0]    rdata_b_i,
  output logic [AW-1:0] raddr_a_o,
  output logic [AW-1:0] raddr_b_o,
  input  logic          res_ready_i,
  output nonc_stat_t    stat_o
);

  localparam int unsigned CW = (LW > 8) ? LW : 8;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_CH_RD = 16'h0002,
    S_CH_EV = 16'h0004,
    S_ZA_RD = 16'h0008,
    S_ZA_EV = 16'h0010,
    S_ZB_RD = 16'h0020,
    S_ZB_EV = 16'h0040,
    S_NA_RD = 16'h0080,
    S_NA_EV = 16'h0100,
    S_NB_RD = 16'h0200,
    S_NB_EV = 16'h0400,
    S_LEN   = 16'h0800,
    S_DG_RD = 16'h1000,
    S_DG_EV = 16'h2000,
    S_FIN   = 16'h4000,
    S_DONE  = 16'h8000
  } walk_state_e;

  walk_state_e state_q, state_d;
  logic [LW-1:0] x_q, x_d, y_q, y_d, sx_q, sx_d, sy_q, sy_d;
  logic [LW-1:0] la_q, la_d, lb_q, lb_d;
  logic signed [1:0] ord_q, ord_d;

  logic [CW-1:0] op_a, op_b;
  logic lt, eq, a_num, b_num, a_zero, b_zero;
  logic a_in, b_in, d_in;
  logic signed [1:0] diff_ord;

  assign a_in     = x_q < la_q;
  assign b_in     = y_q < lb_q;
  assign d_in     = sx_q < x_q;
  assign diff_ord = lt ? ORD_LT : ORD_GT;

  // Digit run lengths go through the same unit as the bytes
  always_comb begin
    if (state_q == S_LEN) begin
      op_a = CW'(LW'(x_q - sx_q));
      op_b = CW'(LW'(y_q - sy_q));
    end else begin
      op_a = CW'(rdata_a_i);
      op_b = CW'(rdata_b_i);
    end
  end

  nonc_cmp #(
    .WIDTH(CW)
  ) u_cmp (
    .a_i     (op_a),
    .b_i     (op_b),
    .fold_i  (state_q == S_CH_EV),
    .lt_o    (lt),
    .eq_o    (eq),
    .a_num_o (a_num),
    .b_num_o (b_num),
    .a_zero_o(a_zero),
    .b_zero_o(b_zero)
  );

  assign raddr_a_o = (state_q == S_DG_RD) ? sx_q[AW-1:0] : x_q[AW-1:0];
  assign raddr_b_o = (state_q == S_DG_RD) ? sy_q[AW-1:0] : y_q[AW-1:0];

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    la_d    = la_q;
    lb_d    = lb_q;
    ord_d   = ord_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          x_d  = '0;
          y_d  = '0;
          la_d = len_a_i;
          lb_d = len_b_i;
          if (dir_a_i != dir_b_i) begin
            ord_d   = dir_a_i ? ORD_LT : ORD_GT;
            state_d = S_DONE;
          end else begin
            state_d = S_CH_RD;
          end
        end
      end
      S_CH_RD: state_d = (a_in && b_in) ? S_CH_EV : S_FIN;
      S_CH_EV: begin
        if (a_num && b_num) begin
          state_d = S_ZA_RD;
        end else if (!eq) begin
          ord_d   = diff_ord;
          state_d = S_DONE;
        end else begin
          x_d     = LW'(x_q + 1'b1);
          y_d     = LW'(y_q + 1'b1);
          state_d = S_CH_RD;
        end
      end
      // Skip leading zeros on each side
      S_ZA_RD: state_d = a_in ? S_ZA_EV : S_ZB_RD;
      S_ZA_EV: begin
        if (a_zero) begin
          x_d     = LW'(x_q + 1'b1);
          state_d = S_ZA_RD;
        end else begin
          state_d = S_ZB_RD;
        end
      end
      S_ZB_RD: begin
        if (b_in) begin
          state_d = S_ZB_EV;
        end else begin
          sx_d    = x_q;
          sy_d    = y_q;
          state_d = S_NA_RD;
        end
      end
      S_ZB_EV: begin
        if (b_zero) begin
          y_d     = LW'(y_q + 1'b1);
          state_d = S_ZB_RD;
        end else begin
          sx_d    = x_q;
          sy_d    = y_q;
          state_d = S_NA_RD;
        end
      end
      // Advance to the end of each digit run
      S_NA_RD: state_d = a_in ? S_NA_EV : S_NB_RD;
      S_NA_EV: begin
        if (a_num) begin
          x_d     = LW'(x_q + 1'b1);
          state_d = S_NA_RD;
        end else begin
          state_d = S_NB_RD;
        end
      end
      S_NB_RD: state_d = b_in ? S_NB_EV : S_LEN;
      S_NB_EV: begin
        if (b_num) begin
          y_d     = LW'(y_q + 1'b1);
          state_d = S_NB_RD;
        end else begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        if (!eq) begin
          ord_d   = diff_ord;
          state_d = S_DONE;
        end else begin
          state_d = S_DG_RD;
        end
      end
      // Equal length runs: first differing digit decides
      S_DG_RD: state_d = d_in ? S_DG_EV : S_CH_RD;
      S_DG_EV: begin
        if (!eq) begin
          ord_d   = diff_ord;
          state_d = S_DONE;
        end else begin
          sx_d    = LW'(sx_q + 1'b1);
          sy_d    = LW'(sy_q + 1'b1);
          state_d = S_DG_RD;
        end
      end
      S_FIN: begin
        if (a_in) begin
          ord_d = ORD_GT;
        end else if (b_in) begin
          ord_d = ORD_LT;
        end else begin
          ord_d = ORD_EQ;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    sx_q  <= sx_d;
    sy_q  <= sy_d;
    la_q  <= la_d;
    lb_q  <= lb_d;
    ord_q <= ord_d;
  end

  assign stat_o.idle  = state_q == S_IDLE;
  assign stat_o.done  = state_q == S_DONE;
  assign stat_o.order = ord_q;

endmodule

>>> rtl/natural_order_name_compare.sv
// ----------------------------------------------------------------------------
// natural_order_name_compare - natural order comparator for two names
// Loads two names byte by byte with directory flags and returns their
// natural sort order: directories first, digit runs by value, letters
// without case.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | transfer when
//  ---------+------------------------------------------+---------------------
//  input    | side_i, ch_i, is_directory_i, last_i     | in_valid_i & in_ready_o
//  output   | order_o                                  | out_valid_o & out_ready_i
//
// A byte that does not complete the pair leaves the input ready for the next byte.
// The byte that completes the pair starts the compare walk: each step is a
// RAM read, then an evaluate in the shared compare unit, one step per
// character pair; a digit run adds per side one step per leading zero, per
// digit and for the byte after each scan, a length compare state, then one
// step per digit pair and a closing read. A scan that meets the end of a
// name stops after its read. Reaching the end of a name takes a read and a
// finish state, then the hand-off; a directory mismatch goes straight to
// the hand-off.
// in_ready_o stays low during the walk and while its order waits for the
// output register. After reset no clearing pass is needed.
// ----------------------------------------------------------------------------
module natural_order_name_compare
  import nonc_pkg::*;
#(
  parameter int unsigned NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              side_i,
  input  logic [7:0]        ch_i,
  input  logic              is_directory_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [1:0] order_o
);

  localparam int unsigned DEPTH = NAME_BYTES - 1;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(NAME_BYTES);

  logic [LW-1:0] len_a_q, len_a_d, len_b_q, len_b_d;
  logic done_a_q, done_a_d, done_b_q, done_b_d;
  logic dir_a_q, dir_a_d, dir_b_q, dir_b_d;
  logic out_valid_q, out_valid_d;
  logic signed [1:0] order_q;

  logic in_xfer, store, pair, res_ready, take;
  logic [LW-1:0] cur_a, cur_b, sel_len, new_len, nxt_a, nxt_b;
  logic nd_a, nd_b;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [7:0] rdata_a, rdata_b;
  nonc_stat_t stat;

  assign in_ready_o = stat.idle;
  assign in_xfer    = in_valid_i && in_ready_o;

  // A byte for a completed name restarts that name
  assign cur_a   = done_a_q ? '0 : len_a_q;
  assign cur_b   = done_b_q ? '0 : len_b_q;
  assign sel_len = side_i ? cur_b : cur_a;
  assign store   = in_xfer && (ch_i != 8'h00) && (sel_len < LW'(DEPTH));
  assign new_len = store ? LW'(sel_len + 1'b1) : sel_len;
  assign nxt_a   = side_i ? len_a_q : new_len;
  assign nxt_b   = side_i ? new_len : len_b_q;
  assign nd_a    = side_i ? done_a_q : last_i;
  assign nd_b    = side_i ? last_i : done_b_q;
  assign pair    = in_xfer && nd_a && nd_b;

  always_comb begin
    len_a_d  = len_a_q;
    len_b_d  = len_b_q;
    done_a_d = done_a_q;
    done_b_d = done_b_q;
    dir_a_d  = dir_a_q;
    dir_b_d  = dir_b_q;
    if (in_xfer) begin
      if (last_i && !side_i) begin
        dir_a_d = is_directory_i;
      end
      if (last_i && side_i) begin
        dir_b_d = is_directory_i;
      end
      if (pair) begin
        len_a_d  = '0;
        len_b_d  = '0;
        done_a_d = 1'b0;
        done_b_d = 1'b0;
      end else begin
        len_a_d  = nxt_a;
        len_b_d  = nxt_b;
        done_a_d = nd_a;
        done_b_d = nd_b;
      end
    end
  end

  nonc_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (store && !side_i),
    .waddr_i(sel_len[AW-1:0]),
    .wdata_i(ch_i),
    .raddr_i(raddr_a),
    .rdata_o(rdata_a)
  );

  nonc_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (store && side_i),
    .waddr_i(sel_len[AW-1:0]),
    .wdata_i(ch_i),
    .raddr_i(raddr_b),
    .rdata_o(rdata_b)
  );

  nonc_walk #(
    .NAME_BYTES(NAME_BYTES)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (pair),
    .dir_a_i    (dir_a_d),
    .dir_b_i    (dir_b_d),
    .len_a_i    (nxt_a),
    .len_b_i    (nxt_b),
    .rdata_a_i  (rdata_a),
    .rdata_b_i  (rdata_b),
    .raddr_a_o  (raddr_a),
    .raddr_b_o  (raddr_b),
    .res_ready_i(res_ready),
    .stat_o     (stat)
  );

  // Output register: take the order once the slot is free
  assign res_ready = !out_valid_q || out_ready_i;
  assign take      = stat.done && res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_a_q     <= '0;
      len_b_q     <= '0;
      done_a_q    <= 1'b0;
      done_b_q    <= 1'b0;
      dir_a_q     <= 1'b0;
      dir_b_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_a_q     <= len_a_d;
      len_b_q     <= len_b_d;
      done_a_q    <= done_a_d;
      done_b_q    <= done_b_d;
      dir_a_q     <= dir_a_d;
      dir_b_q     <= dir_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      order_q <= stat.order;
    end
  end

  assign out_valid_o = out_valid_q;
  assign order_o     = order_q;

  // A completed pair starts the walk and closes the input
  a_pair_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair |=> !in_ready_o)
    else $error("walk did not start on a completed pair");

  // Stored lengths never pass the buffer depth
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_a_q <= LW'(DEPTH)) && (len_b_q <= LW'(DEPTH)))
    else $error("name length beyond buffer depth");

  // No order code outside -1, 0, 1 leaves the block
  a_order_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (order_o == ORD_LT || order_o == ORD_EQ || order_o == ORD_GT))
    else $error("invalid order code");

  // Both names are cleared after the pair is handed to the walk
  a_pair_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair |=> (!done_a_q && !done_b_q && len_a_q == '0 && len_b_q == '0))
    else $error("names not cleared after pair");

endmodule
